### rtl/sk256_pkg.sv
// Shared types, constants and helpers for the Skein-256 UBI compression block.
// Holds the Threefish-256 rotation table, key parity, IV reset words and the inject step.
// No dependencies.
`default_nettype none

package sk256_pkg;

    typedef logic [63:0] word_t;
    typedef word_t [3:0] block_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    localparam int NUM_STEPS   = 18;
    localparam int STEP_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int TYPE_W      = 6;
    localparam int CFG_INDEX_W = 2;

    localparam word_t KS_PARITY = 64'h1BD11BDAA9FC1A22;

    localparam word_t IV_RESET0 = 64'hFC9DA860D048B449;
    localparam word_t IV_RESET1 = 64'h2FCA66479FA7D833;
    localparam word_t IV_RESET2 = 64'hB33BC3896656840F;
    localparam word_t IV_RESET3 = 64'h6A54E920FDE8DA69;

    localparam logic [1:0] CFG_IV0 = 2'd0;
    localparam logic [1:0] CFG_IV1 = 2'd1;
    localparam logic [1:0] CFG_IV2 = 2'd2;
    localparam logic [1:0] CFG_IV3 = 2'd3;

    localparam logic [5:0] ROT_TAB [8][2] = '{
        '{6'd14, 6'd16}, '{6'd52, 6'd57}, '{6'd23, 6'd40}, '{6'd5,  6'd37},
        '{6'd25, 6'd33}, '{6'd46, 6'd12}, '{6'd58, 6'd22}, '{6'd32, 6'd32}
    };

    function automatic word_t rotl64(input word_t x, input logic [5:0] r);
        logic [6:0] rr;
        rr = 7'd64 - {1'b0, r};
        return (x << r) | (x >> rr);
    endfunction

    function automatic block_t inject(
        input block_t            v,
        input block_t            k,
        input word_t             t0,
        input word_t             t1,
        input logic [STEP_W-1:0] s
    );
        block_t res;
        res[0] = v[0] + k[0];
        res[1] = v[1] + k[1] + t0;
        res[2] = v[2] + k[2] + t1;
        res[3] = v[3] + k[3] + {{(64-STEP_W){1'b0}}, s};
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/sk256_round4.sv
// Four Threefish-256 MIX/permute rounds, the shared datapath of the block.
// Depends on sk256_pkg for word types and the rotation table.
`default_nettype none

module sk256_round4
    import sk256_pkg::*;
(
    input  block_t v_in,
    input  logic   odd,
    output block_t v_out
);

    block_t v_stage [5];

    assign v_stage[0] = v_in;

    for (genvar d = 0; d < 4; d++) begin : g_round
        word_t      a0;
        word_t      a1;
        word_t      a2;
        word_t      a3;
        logic [5:0] r0;
        logic [5:0] r1;

        assign r0 = odd ? ROT_TAB[d + 4][0] : ROT_TAB[d][0];
        assign r1 = odd ? ROT_TAB[d + 4][1] : ROT_TAB[d][1];
        assign a0 = v_stage[d][0] + v_stage[d][1];
        assign a1 = rotl64(v_stage[d][1], r0) ^ a0;
        assign a2 = v_stage[d][2] + v_stage[d][3];
        assign a3 = rotl64(v_stage[d][3], r1) ^ a2;

        assign v_stage[d + 1][0] = a0;
        assign v_stage[d + 1][1] = a3;
        assign v_stage[d + 1][2] = a2;
        assign v_stage[d + 1][3] = a1;
    end

    assign v_out = v_stage[4];

endmodule

`default_nettype wire

### rtl/skein256_ubi_compression.sv
// Skein-256 UBI compression top level: chaining state, key schedule and sequencer.
// Depends on sk256_pkg and sk256_round4.
//
//   channel | direction | signals
//   --------+-----------+--------------------------------------------------------
//   in      | to block  | in_valid, in_stall, msg_word0..3, byte_count, block_type,
//           |           | first_flag, final_flag, restart_position, load_iv
//   out     | from block| out_valid, out_stall, chain_word0..3
//   cfg     | to block  | cfg_write, cfg_index, cfg_data
//
// The input beat loads the first subkey, then 18 passes through the four-round unit
// follow, each ending in an injection; out_valid rises as the last pass completes.
// in_stall is high during those 18 passes, so no new beat is taken until they are done.
// The last pass waits while a previous output beat is still stalled. Reset loads the
// standard IV and clears chain and position.
`default_nettype none

module skein256_ubi_compression
    import sk256_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]            cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [63:0]            msg_word0,
    input  wire logic [63:0]            msg_word1,
    input  wire logic [63:0]            msg_word2,
    input  wire logic [63:0]            msg_word3,
    input  wire logic [COUNT_W-1:0]     byte_count,
    input  wire logic [TYPE_W-1:0]      block_type,
    input  wire logic                   first_flag,
    input  wire logic                   final_flag,
    input  wire logic                   restart_position,
    input  wire logic                   load_iv,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [63:0]                 chain_word0,
    output logic [63:0]                 chain_word1,
    output logic [63:0]                 chain_word2,
    output logic [63:0]                 chain_word3
);

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    block_t              iv_reg;
    block_t              chain_reg;
    word_t               pos_reg;
    block_t              v_reg;
    block_t              msg_reg;
    word_t               ks_reg [5];
    word_t               tw_reg [3];
    logic                out_valid_reg;
    block_t              out_reg;

    logic                accept;
    logic                last_step;
    logic                advance;
    block_t              msg_in;
    block_t              key_in;
    word_t               key_par;
    word_t               pos_next;
    word_t               tw1_in;
    word_t               tw2_in;
    block_t              v_first;
    block_t              v_mixed;
    block_t              v_next;
    block_t              ks_cur;
    block_t              result;

    assign msg_in = {msg_word3, msg_word2, msg_word1, msg_word0};
    assign key_in = load_iv ? iv_reg : chain_reg;
    assign key_par = KS_PARITY ^ key_in[0] ^ key_in[1] ^ key_in[2] ^ key_in[3];
    assign pos_next = restart_position ? {{(64-COUNT_W){1'b0}}, byte_count}
                                       : pos_reg + {{(64-COUNT_W){1'b0}}, byte_count};
    assign tw1_in = {final_flag, first_flag, block_type, 56'd0};
    assign tw2_in = pos_next ^ tw1_in;
    assign v_first = inject(msg_in, key_in, pos_next, tw1_in, '0);

    assign ks_cur = {ks_reg[3], ks_reg[2], ks_reg[1], ks_reg[0]};

    sk256_round4 u_round4 (
        .v_in  (v_reg),
        .odd   (~step_reg[0]),
        .v_out (v_mixed)
    );

    assign v_next = inject(v_mixed, ks_cur, tw_reg[0], tw_reg[1], step_reg);
    assign result = v_next ^ msg_reg;

    assign in_stall  = (state_reg == ST_RUN);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign last_step = (step_reg == STEP_W'(NUM_STEPS));
    assign advance   = (state_reg == ST_RUN) && !(last_step && out_valid_reg && out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (advance && last_step)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            iv_reg        <= {IV_RESET3, IV_RESET2, IV_RESET1, IV_RESET0};
            chain_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_IV0: iv_reg[0] <= cfg_data;
                    CFG_IV1: iv_reg[1] <= cfg_data;
                    CFG_IV2: iv_reg[2] <= cfg_data;
                    CFG_IV3: iv_reg[3] <= cfg_data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                chain_reg <= key_in;
                pos_reg   <= pos_next;
                step_reg  <= STEP_W'(1);
            end
            else if (advance)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                    chain_reg <= result;
            end

            if (advance && last_step)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg     <= v_first;
            msg_reg   <= msg_in;
            ks_reg[0] <= key_in[1];
            ks_reg[1] <= key_in[2];
            ks_reg[2] <= key_in[3];
            ks_reg[3] <= key_par;
            ks_reg[4] <= key_in[0];
            tw_reg[0] <= tw1_in;
            tw_reg[1] <= tw2_in;
            tw_reg[2] <= pos_next;
        end
        else if (advance)
        begin
            v_reg     <= v_next;
            ks_reg[0] <= ks_reg[1];
            ks_reg[1] <= ks_reg[2];
            ks_reg[2] <= ks_reg[3];
            ks_reg[3] <= ks_reg[4];
            ks_reg[4] <= ks_reg[0];
            tw_reg[0] <= tw_reg[1];
            tw_reg[1] <= tw_reg[2];
            tw_reg[2] <= tw_reg[0];
            if (last_step)
                out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign chain_word0 = out_reg[0];
    assign chain_word1 = out_reg[1];
    assign chain_word2 = out_reg[2];
    assign chain_word3 = out_reg[3];

endmodule

`default_nettype wire
